// ===== hdl/arp_resolver_responder_core_macros.svh =====
`ifndef ARP_RESOLVER_RESPONDER_CORE_MACROS_SVH
`define ARP_RESOLVER_RESPONDER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARP_RR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp_rr same-cycle check failed");

// next-cycle implication, checked out of reset
`define ARP_RR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp_rr next-cycle check failed");

`endif

// ===== hdl/arp_rr_pkg.sv =====
package arp_rr_pkg;

    // result kinds
    localparam logic [2:0] K_SEND     = 3'd0;
    localparam logic [2:0] K_HELD     = 3'd1;
    localparam logic [2:0] K_REQ      = 3'd2;
    localparam logic [2:0] K_REPLY    = 3'd3;
    localparam logic [2:0] K_RESOLVED = 3'd4;
    localparam logic [2:0] K_MCAST    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_LOCAL_IP      = 3'd0;
    localparam logic [2:0] CFG_SUBNET_MASK   = 3'd1;
    localparam logic [2:0] CFG_GATEWAY_IP    = 3'd2;
    localparam logic [2:0] CFG_LOCAL_MAC     = 3'd3;
    localparam logic [2:0] CFG_ADDRESS_VALID = 3'd4;

    // arp header values
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] LINK_LOCAL_HI = 16'hA9FE;
    localparam logic [3:0]  MCAST_NIBBLE  = 4'hE;

    localparam logic [31:0] IP_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_ZERO     = 48'h0000_0000_0000;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_ip;
        logic [47:0] local_mac;
        logic        address_valid;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] dest_ip;
        logic        long_enough;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [47:0] frame_source_mac;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic        last;
    } result_t;

    typedef struct packed {
        logic ip_we;
        logic mac_we;
    } tbl_wr_t;

endpackage

// ===== hdl/arp_rr_table.sv =====
module arp_rr_table #(
    parameter int TABLE_ENTRIES = 16,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic                 clk,
    input  arp_rr_pkg::tbl_wr_t  wr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [31:0]          wr_ip,
    input  logic [47:0]          wr_mac,
    input  logic [AW-1:0]        rd_addr,
    output logic [31:0]          rd_ip,
    output logic [47:0]          rd_mac
);
    import arp_rr_pkg::*;

    logic [31:0] ip_mem  [TABLE_ENTRIES];
    logic [47:0] mac_mem [TABLE_ENTRIES];
    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.ip_we)
        begin
            ip_mem[wr_addr] <= wr_ip;
        end
        if (wr.mac_we)
        begin
            mac_mem[wr_addr] <= wr_mac;
        end
        rd_ip_reg  <= ip_mem[rd_addr];
        rd_mac_reg <= mac_mem[rd_addr];
    end

    assign rd_ip  = rd_ip_reg;
    assign rd_mac = rd_mac_reg;

endmodule

// ===== hdl/arp_rr_seq.sv =====
module arp_rr_seq #(
    parameter int TABLE_ENTRIES = 16,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  arp_rr_pkg::item_t    item,
    input  arp_rr_pkg::cfg_t     cfg,
    output arp_rr_pkg::result_t  result,
    output arp_rr_pkg::tbl_wr_t  tbl_wr,
    output logic [AW-1:0]        tbl_wr_addr,
    output logic [31:0]          tbl_wr_ip,
    output logic [47:0]          tbl_wr_mac,
    output logic [AW-1:0]        tbl_rd_addr,
    input  logic [31:0]          tbl_rd_ip,
    input  logic [47:0]          tbl_rd_mac
);
    import arp_rr_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_TAIL = 6'b001000,
        ST_ACT  = 6'b010000,
        ST_OUT2 = 6'b100000
    } state_t;

    // control state
    state_t                   state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] used_reg, used_next;
    logic [TABLE_ENTRIES-1:0] resolved_reg, resolved_next;
    logic [AW-1:0]            rp_reg, rp_next;
    logic [AW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic                     cmp_used_reg, cmp_used_next;
    logic [AW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                     hit_reg, hit_next;
    logic [AW-1:0]            hit_idx_reg, hit_idx_next;
    logic                     free_reg, free_next;
    logic [AW-1:0]            free_idx_reg, free_idx_next;
    logic                     res_valid_reg, res_valid_next;

    // payload
    item_t       item_reg, item_next;
    logic [31:0] key_reg, key_next;
    logic [47:0] hit_mac_reg, hit_mac_next;
    logic        for_us_reg, for_us_next;
    logic        reply_reg, reply_next;
    logic [2:0]  res_kind_reg, res_kind_next;
    logic [47:0] res_mac_reg, res_mac_next;
    logic [31:0] res_ip_reg, res_ip_next;
    logic        res_last_reg, res_last_next;
    logic [2:0]  sec_kind_reg, sec_kind_next;
    logic [47:0] sec_mac_reg, sec_mac_next;

    // decode of the latched item
    logic          is_bcast, is_mcast, off_net, arp_good, for_us, reply;
    logic          was_pending;
    logic [AW-1:0] slot;
    logic [AW-1:0] rp_adv;

    assign is_bcast = (item_reg.dest_ip == IP_ALL_ONES) ||
                      (cfg.address_valid &&
                       item_reg.dest_ip == (cfg.local_ip | ~cfg.subnet_mask));
    assign is_mcast = (item_reg.dest_ip[31:28] == MCAST_NIBBLE);
    assign off_net  = (((item_reg.dest_ip ^ cfg.local_ip) & cfg.subnet_mask) != 32'd0) &&
                      (item_reg.dest_ip[31:16] != LINK_LOCAL_HI);
    assign arp_good = item_reg.long_enough && (item_reg.hw_type == HTYPE_ETH) &&
                      (item_reg.proto_type == PTYPE_IPV4);
    assign for_us   = cfg.address_valid && (item_reg.target_ip == cfg.local_ip);
    assign reply    = for_us && (item_reg.operation == OP_REQUEST);

    assign was_pending = !resolved_reg[hit_idx_reg];
    assign slot        = free_reg ? free_idx_reg : rp_reg;
    assign rp_adv      = (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        resolved_next  = resolved_reg;
        rp_next        = rp_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_used_next  = cmp_used_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        res_valid_next = 1'b0;
        item_next      = item_reg;
        key_next       = key_reg;
        hit_mac_next   = hit_mac_reg;
        for_us_next    = for_us_reg;
        reply_next     = reply_reg;
        res_kind_next  = res_kind_reg;
        res_mac_next   = res_mac_reg;
        res_ip_next    = res_ip_reg;
        res_last_next  = res_last_reg;
        sec_kind_next  = sec_kind_reg;
        sec_mac_next   = sec_mac_reg;
        tbl_wr         = '0;
        tbl_wr_addr    = hit_idx_reg;
        tbl_wr_ip      = key_reg;
        tbl_wr_mac     = item_reg.sender_mac;
        tbl_rd_addr    = scan_idx_reg;

        // shared compare: one table entry against the key per cycle
        if (cmp_vld_reg && cmp_used_reg && !hit_reg && (tbl_rd_ip == key_reg))
        begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
            hit_mac_next = tbl_rd_mac;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                scan_idx_next = '0;
                cmp_vld_next  = 1'b0;
                hit_next      = 1'b0;
                free_next     = 1'b0;
                for_us_next   = for_us;
                reply_next    = reply;
                key_next      = item_reg.cmd ? item_reg.sender_ip :
                                (off_net ? cfg.gateway_ip : item_reg.dest_ip);
                state_next    = ST_SCAN;
                if (!item_reg.cmd)
                begin
                    priority if (is_bcast)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = K_SEND;
                        res_mac_next   = MAC_ALL_ONES;
                        res_ip_next    = item_reg.dest_ip;
                        res_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (is_mcast)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = K_MCAST;
                        res_mac_next   = MAC_ZERO;
                        res_ip_next    = item_reg.dest_ip;
                        res_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (!cfg.address_valid)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else if (!arp_good)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                cmp_used_next = used_reg[scan_idx_reg];
                // lowest unused entry
                if (!used_reg[scan_idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = scan_idx_reg;
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                cmp_vld_next = 1'b0;
                state_next   = ST_ACT;
            end
            ST_ACT:
            begin
                state_next = ST_IDLE;
                if (!item_reg.cmd)
                begin
                    priority if (!hit_reg)
                    begin
                        // miss: insert a pending entry, request then hold
                        tbl_wr.ip_we        = 1'b1;
                        tbl_wr_addr         = slot;
                        used_next[slot]     = 1'b1;
                        resolved_next[slot] = 1'b0;
                        if (!free_reg)
                        begin
                            rp_next = rp_adv;
                        end
                        res_valid_next = 1'b1;
                        res_kind_next  = K_REQ;
                        res_mac_next   = MAC_ALL_ONES;
                        res_ip_next    = key_reg;
                        res_last_next  = 1'b0;
                        sec_kind_next  = K_HELD;
                        sec_mac_next   = MAC_ZERO;
                        state_next     = ST_OUT2;
                    end
                    else if (was_pending)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = K_HELD;
                        res_mac_next   = MAC_ZERO;
                        res_ip_next    = key_reg;
                        res_last_next  = 1'b1;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = K_SEND;
                        res_mac_next   = hit_mac_reg;
                        res_ip_next    = key_reg;
                        res_last_next  = 1'b1;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        // update the matching entry
                        tbl_wr.mac_we              = 1'b1;
                        tbl_wr_addr                = hit_idx_reg;
                        resolved_next[hit_idx_reg] = 1'b1;
                        if (was_pending)
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = K_RESOLVED;
                            res_mac_next   = item_reg.sender_mac;
                            res_ip_next    = key_reg;
                            res_last_next  = !reply_reg;
                        end
                    end
                    else if (for_us_reg)
                    begin
                        // new resolved entry for a peer whose packet targets our address
                        tbl_wr.ip_we        = 1'b1;
                        tbl_wr.mac_we       = 1'b1;
                        tbl_wr_addr         = slot;
                        used_next[slot]     = 1'b1;
                        resolved_next[slot] = 1'b1;
                        if (!free_reg)
                        begin
                            rp_next = rp_adv;
                        end
                    end
                    if (reply_reg)
                    begin
                        if (hit_reg && was_pending)
                        begin
                            sec_kind_next = K_REPLY;
                            sec_mac_next  = item_reg.frame_source_mac;
                            state_next    = ST_OUT2;
                        end
                        else
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = K_REPLY;
                            res_mac_next   = item_reg.frame_source_mac;
                            res_ip_next    = key_reg;
                            res_last_next  = 1'b1;
                        end
                    end
                end
            end
            ST_OUT2:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = sec_kind_reg;
                res_mac_next   = sec_mac_reg;
                res_ip_next    = key_reg;
                res_last_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            resolved_reg  <= '0;
            rp_reg        <= '0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_used_reg  <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            resolved_reg  <= resolved_next;
            rp_reg        <= rp_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_used_reg  <= cmp_used_next;
            cmp_idx_reg   <= cmp_idx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        key_reg      <= key_next;
        hit_mac_reg  <= hit_mac_next;
        for_us_reg   <= for_us_next;
        reply_reg    <= reply_next;
        res_kind_reg <= res_kind_next;
        res_mac_reg  <= res_mac_next;
        res_ip_reg   <= res_ip_next;
        res_last_reg <= res_last_next;
        sec_kind_reg <= sec_kind_next;
        sec_mac_reg  <= sec_mac_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.kind  = res_kind_reg;
    assign result.mac   = res_mac_reg;
    assign result.ip    = res_ip_reg;
    assign result.last  = res_last_reg;

endmodule

// ===== hdl/arp_resolver_responder_core.sv =====
// ARP resolver and responder. An item is taken at a clock edge with start high and busy
// low; a resolve item maps an outbound IPv4 destination to a next-hop MAC, a receive item
// checks an ARP packet, updates or adds a table entry and answers requests. Broadcast,
// multicast, dropped resolves and bad ARP packets end in the prep state; every other item
// walks the whole table through its single read port, one entry per cycle, and then
// passes the tail and act states, and the out2 state when it gives two results.
// Results come out on result_valid for exactly one cycle each and cannot be stalled;
// a second result always follows the first in the next cycle, and the last result of an
// item is shown in the cycle busy falls. Configuration writes are always ready and must
// only be issued while the block is idle.
`include "arp_resolver_responder_core_macros.svh"

module arp_resolver_responder_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] dest_ip,
    input  logic        long_enough,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] operation,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    input  logic [47:0] frame_source_mac,
    // result channel
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic [47:0] peer_mac,
    output logic [31:0] peer_ip,
    output logic        last,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import arp_rr_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [31:0] local_ip_reg;
    logic [31:0] subnet_mask_reg;
    logic [31:0] gateway_ip_reg;
    logic [47:0] local_mac_reg;
    logic        address_valid_reg;

    cfg_t          cfg;
    item_t         item;
    result_t       result;
    tbl_wr_t       tbl_wr;
    logic [AW-1:0] tbl_wr_addr;
    logic [31:0]   tbl_wr_ip;
    logic [47:0]   tbl_wr_mac;
    logic [AW-1:0] tbl_rd_addr;
    logic [31:0]   tbl_rd_ip;
    logic [47:0]   tbl_rd_mac;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg      <= '0;
            subnet_mask_reg   <= '0;
            gateway_ip_reg    <= '0;
            local_mac_reg     <= '0;
            address_valid_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOCAL_IP:      local_ip_reg      <= cfg_data[31:0];
                CFG_SUBNET_MASK:   subnet_mask_reg   <= cfg_data[31:0];
                CFG_GATEWAY_IP:    gateway_ip_reg    <= cfg_data[31:0];
                CFG_LOCAL_MAC:     local_mac_reg     <= cfg_data;
                CFG_ADDRESS_VALID: address_valid_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign cfg.local_ip      = local_ip_reg;
    assign cfg.subnet_mask   = subnet_mask_reg;
    assign cfg.gateway_ip    = gateway_ip_reg;
    assign cfg.local_mac     = local_mac_reg;
    assign cfg.address_valid = address_valid_reg;

    // input beat
    assign item.cmd              = cmd;
    assign item.dest_ip          = dest_ip;
    assign item.long_enough      = long_enough;
    assign item.hw_type          = hw_type;
    assign item.proto_type       = proto_type;
    assign item.operation        = operation;
    assign item.sender_mac       = sender_mac;
    assign item.sender_ip        = sender_ip;
    assign item.target_ip        = target_ip;
    assign item.frame_source_mac = frame_source_mac;

    arp_rr_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg         (cfg),
        .result      (result),
        .tbl_wr      (tbl_wr),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_ip   (tbl_wr_ip),
        .tbl_wr_mac  (tbl_wr_mac),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_ip   (tbl_rd_ip),
        .tbl_rd_mac  (tbl_rd_mac)
    );

    arp_rr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .wr_ip   (tbl_wr_ip),
        .wr_mac  (tbl_wr_mac),
        .rd_addr (tbl_rd_addr),
        .rd_ip   (tbl_rd_ip),
        .rd_mac  (tbl_rd_mac)
    );

    // result beat
    assign result_valid = result.valid;
    assign kind         = result.kind;
    assign peer_mac     = result.mac;
    assign peer_ip      = result.ip;
    assign last         = result.last;

    // checks
    `ARP_RR_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `ARP_RR_ASSERT_NEXT(a_pair_back_to_back, result_valid && !last, result_valid && last)
    `ARP_RR_ASSERT_NOW(a_last_frees_block, result_valid && last, !busy)
    `ARP_RR_ASSERT_NOW(a_request_bcast, result_valid && kind == K_REQ, peer_mac == MAC_ALL_ONES && !last)

endmodule

// ===== sim/tb_arp_resolver_responder_core.sv =====
`default_nettype none

module tb_arp_resolver_responder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import arp_rr_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 5;
    localparam int PHASE_ITEMS = 130;
    localparam int MAX_GAP = 30;

    localparam cfg_t DIR_CFG = '{32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101,
                                 48'h02AA_BBCC_DDEE, 1'b1};

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic        last;
    } arp_result_t;

    typedef struct {
        bit          addressed;
        item_t       it;
        bit          typed;
        int          n;
        arp_result_t r0;
        arp_result_t r1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = 1'b0;
    logic [31:0] dest_ip = '0;
    logic        long_enough = 1'b0;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [15:0] operation = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic [47:0] frame_source_mac = '0;
    logic        result_valid;
    logic [2:0]  kind;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_LOCAL_IP;
    logic [47:0] cfg_data = '0;

    // typed expectation that travels with the item being offered
    bit          row_typed = 1'b0;
    int          row_n = 0;
    arp_result_t row_res [2];

    // predictor state
    cfg_t        cur_cfg = '0;
    bit          tbl_used [TABLE_ENTRIES];
    bit          tbl_resolved [TABLE_ENTRIES];
    logic [31:0] tbl_ip [TABLE_ENTRIES];
    logic [47:0] tbl_mac [TABLE_ENTRIES];
    int          repl_ptr = 0;
    int          outcome_n;
    arp_result_t outcome_res [2];
    arp_result_t results_due [$];

    int          mismatches = 0;
    int          cycles = 0;
    item_t       seen_item;
    arp_result_t want_res;
    stim_row_t   directed_rows [$];

    arp_resolver_responder_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_dut (.*);

    always #HALF_PERIOD clk = ~clk;

    // ---------------- predictor ----------------

    function automatic int find_entry(input logic [31:0] ip);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_used[i] && tbl_ip[i] == ip)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // lowest free slot, else round-robin replacement
    function automatic void add_entry(input logic [31:0] ip, input bit resolved,
                                      input logic [47:0] mac);
        int slot;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!tbl_used[i] && slot < 0)
            begin
                slot = i;
            end
        end
        if (slot < 0)
        begin
            slot = repl_ptr;
            repl_ptr = (repl_ptr + 1) % TABLE_ENTRIES;
        end
        tbl_used[slot] = 1'b1;
        tbl_resolved[slot] = resolved;
        tbl_ip[slot] = ip;
        tbl_mac[slot] = resolved ? mac : MAC_ZERO;
    endfunction

    function automatic void note(input logic [2:0] k, input logic [47:0] mac,
                                 input logic [31:0] ip, input logic fin);
        outcome_res[outcome_n] = '{k, mac, ip, fin};
        outcome_n++;
    endfunction

    // results caused by one item, table updated on the way
    function automatic void arp_outcome(input item_t it);
        logic [31:0] hop;
        int          e;
        bit          for_us;
        bit          answer;
        bit          was_pending;
        outcome_n = 0;
        if (!it.cmd)
        begin
            hop = it.dest_ip;
            if (it.dest_ip == IP_ALL_ONES || (cur_cfg.address_valid &&
                it.dest_ip == (cur_cfg.local_ip | ~cur_cfg.subnet_mask)))
            begin
                note(K_SEND, MAC_ALL_ONES, it.dest_ip, 1'b1);
            end
            else if (it.dest_ip[31:28] == MCAST_NIBBLE)
            begin
                note(K_MCAST, MAC_ZERO, it.dest_ip, 1'b1);
            end
            else if (cur_cfg.address_valid)
            begin
                // off-subnet and not link-local goes to the gateway
                if (((it.dest_ip ^ cur_cfg.local_ip) & cur_cfg.subnet_mask) != '0 &&
                    it.dest_ip[31:16] != LINK_LOCAL_HI)
                begin
                    hop = cur_cfg.gateway_ip;
                end
                e = find_entry(hop);
                if (e < 0)
                begin
                    add_entry(hop, 1'b0, MAC_ZERO);
                    note(K_REQ, MAC_ALL_ONES, hop, 1'b0);
                    note(K_HELD, MAC_ZERO, hop, 1'b1);
                end
                else if (!tbl_resolved[e])
                begin
                    note(K_HELD, MAC_ZERO, hop, 1'b1);
                end
                else
                begin
                    note(K_SEND, tbl_mac[e], hop, 1'b1);
                end
            end
        end
        else if (it.long_enough && it.hw_type == HTYPE_ETH && it.proto_type == PTYPE_IPV4)
        begin
            for_us = cur_cfg.address_valid && it.target_ip == cur_cfg.local_ip;
            answer = for_us && it.operation == OP_REQUEST;
            e = find_entry(it.sender_ip);
            if (e >= 0)
            begin
                was_pending = !tbl_resolved[e];
                tbl_mac[e] = it.sender_mac;
                tbl_resolved[e] = 1'b1;
                if (was_pending)
                begin
                    note(K_RESOLVED, it.sender_mac, it.sender_ip, !answer);
                end
            end
            else if (for_us)
            begin
                add_entry(it.sender_ip, 1'b1, it.sender_mac);
            end
            if (answer)
            begin
                note(K_REPLY, it.frame_source_mac, it.sender_ip, 1'b1);
            end
        end
    endfunction

    // ---------------- result checking ----------------

    function automatic void report(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result beat against the oldest expectation
            if (result_valid)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got kind %0d ip %0h",
                             $time, kind, peer_ip);
                end
                else
                begin
                    want_res = results_due.pop_front();
                    if (kind !== want_res.kind)
                    begin
                        report("kind", want_res.kind, kind);
                    end
                    if (peer_mac !== want_res.mac)
                    begin
                        report("peer_mac", want_res.mac, peer_mac);
                    end
                    if (peer_ip !== want_res.ip)
                    begin
                        report("peer_ip", want_res.ip, peer_ip);
                    end
                    if (last !== want_res.last)
                    begin
                        report("last", want_res.last, last);
                    end
                end
            end

            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOCAL_IP:      cur_cfg.local_ip = cfg_data[31:0];
                    CFG_SUBNET_MASK:   cur_cfg.subnet_mask = cfg_data[31:0];
                    CFG_GATEWAY_IP:    cur_cfg.gateway_ip = cfg_data[31:0];
                    CFG_LOCAL_MAC:     cur_cfg.local_mac = cfg_data;
                    CFG_ADDRESS_VALID: cur_cfg.address_valid = cfg_data[0];
                    default: ;
                endcase
            end

            // accepted item beat
            if (start && !busy)
            begin
                seen_item.cmd = cmd;
                seen_item.dest_ip = dest_ip;
                seen_item.long_enough = long_enough;
                seen_item.hw_type = hw_type;
                seen_item.proto_type = proto_type;
                seen_item.operation = operation;
                seen_item.sender_mac = sender_mac;
                seen_item.sender_ip = sender_ip;
                seen_item.target_ip = target_ip;
                seen_item.frame_source_mac = frame_source_mac;
                arp_outcome(seen_item);
                if (row_typed)
                begin
                    for (int i = 0; i < row_n; i++)
                    begin
                        results_due.push_back(row_res[i]);
                    end
                end
                else
                begin
                    for (int i = 0; i < outcome_n; i++)
                    begin
                        results_due.push_back(outcome_res[i]);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic arp_result_t mk_res(input logic [2:0] k, input logic [47:0] mac,
                                           input logic [31:0] ip, input logic fin);
        return '{k, mac, ip, fin};
    endfunction

    function automatic item_t rslv(input logic [31:0] dest);
        item_t x;
        x = '0;
        x.dest_ip = dest;
        return x;
    endfunction

    function automatic item_t arp_pkt(input logic le, input logic [15:0] ht,
                                      input logic [15:0] pt, input logic [15:0] op,
                                      input logic [47:0] smac, input logic [31:0] sip,
                                      input logic [31:0] tip, input logic [47:0] fsrc);
        item_t x;
        x = '0;
        x.cmd = 1'b1;
        x.long_enough = le;
        x.hw_type = ht;
        x.proto_type = pt;
        x.operation = op;
        x.sender_mac = smac;
        x.sender_ip = sip;
        x.target_ip = tip;
        x.frame_source_mac = fsrc;
        return x;
    endfunction

    // n < 0: checked against the predictor, else n typed results
    function automatic void add_row(input bit addressed, input item_t it, input int n = -1,
                                    input arp_result_t r0 = '0, input arp_result_t r1 = '0);
        stim_row_t r;
        r.addressed = addressed;
        r.it = it;
        r.typed = (n >= 0);
        r.n = (n >= 0) ? n : 0;
        r.r0 = r0;
        r.r1 = r1;
        directed_rows.push_back(r);
    endfunction

    // addresses that hit the table often: local hosts, gateway, link-local, remote
    function automatic logic [31:0] pool_ip(input cfg_t c);
        logic [31:0] host;
        int          pick;
        host = 32'($urandom_range(1, 24));
        pick = $urandom_range(9);
        if (pick <= 5)
        begin
            return (c.local_ip & c.subnet_mask) | (host & ~c.subnet_mask);
        end
        if (pick == 6)
        begin
            return c.gateway_ip;
        end
        if (pick == 7)
        begin
            return {LINK_LOCAL_HI, 16'($urandom_range(1, 6))};
        end
        if (pick == 8)
        begin
            return {24'h08_0808, 8'($urandom_range(1, 4))};
        end
        return $urandom;
    endfunction

    // mostly well-formed traffic, some broken packets and odd destinations
    function automatic item_t rand_item(input cfg_t c);
        item_t x;
        int    pick;
        x.cmd = 1'($urandom_range(1));
        x.dest_ip = $urandom;
        x.long_enough = 1'($urandom_range(1));
        x.hw_type = 16'($urandom);
        x.proto_type = 16'($urandom);
        x.operation = 16'($urandom);
        x.sender_mac = rand48();
        x.sender_ip = $urandom;
        x.target_ip = $urandom;
        x.frame_source_mac = rand48();
        pick = $urandom_range(99);
        if (!x.cmd)
        begin
            if (pick < 85)
            begin
                x.dest_ip = pool_ip(c);
            end
            else if (pick < 90)
            begin
                x.dest_ip = IP_ALL_ONES;
            end
            else if (pick < 94)
            begin
                x.dest_ip = c.local_ip | ~c.subnet_mask;
            end
            else if (pick < 98)
            begin
                x.dest_ip = {MCAST_NIBBLE, 28'($urandom)};
            end
        end
        else
        begin
            x.long_enough = ($urandom_range(19) != 0);
            if ($urandom_range(19) != 0)
            begin
                x.hw_type = HTYPE_ETH;
            end
            if ($urandom_range(19) != 0)
            begin
                x.proto_type = PTYPE_IPV4;
            end
            if (pick < 45)
            begin
                x.operation = OP_REQUEST;
            end
            else if (pick < 85)
            begin
                x.operation = 16'd2;
            end
            x.sender_ip = pool_ip(c);
            if ($urandom_range(9) < 7)
            begin
                x.target_ip = c.local_ip;
            end
            else if ($urandom_range(1) == 0)
            begin
                x.target_ip = pool_ip(c);
            end
        end
        return x;
    endfunction

    // offer one item and hold it until the accepting edge
    task automatic drive_item(input stim_row_t r);
        start <= 1'b1;
        cmd <= r.it.cmd;
        dest_ip <= r.it.dest_ip;
        long_enough <= r.it.long_enough;
        hw_type <= r.it.hw_type;
        proto_type <= r.it.proto_type;
        operation <= r.it.operation;
        sender_mac <= r.it.sender_mac;
        sender_ip <= r.it.sender_ip;
        target_ip <= r.it.target_ip;
        frame_source_mac <= r.it.frame_source_mac;
        row_typed <= r.typed;
        row_n <= r.n;
        row_res[0] <= r.r0;
        row_res[1] <= r.r1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    // stop offering, drain every expected result, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_regs(input cfg_t c);
        wait_idle();
        write_reg(CFG_LOCAL_IP, {16'h0, c.local_ip});
        write_reg(CFG_SUBNET_MASK, {16'h0, c.subnet_mask});
        write_reg(CFG_GATEWAY_IP, {16'h0, c.gateway_ip});
        write_reg(CFG_LOCAL_MAC, c.local_mac);
        write_reg(CFG_ADDRESS_VALID, {47'h0, c.address_valid});
        cfg_valid <= 1'b0;
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        stim_row_t row;
        bit        configured;
        cfg_t      phase_cfg [PHASE_COUNT];
        int        phase_idle [PHASE_COUNT];

        configured = 1'b0;
        phase_idle = '{0, 48, 12, 48, 0};
        phase_cfg[0] = '{32'h0A01_0203, 32'hFFFF_FF00, 32'h0A01_0201, 48'h0200_1122_3344, 1'b1};
        phase_cfg[1] = '{32'hAC10_2A05, 32'hFFFF_FFF0, 32'hAC10_2A01, rand48(), 1'b1};
        phase_cfg[2] = '{$urandom, 32'h0000_0000, $urandom, MAC_ZERO, 1'b1};
        phase_cfg[3] = '{32'hFFFF_FFFE, IP_ALL_ONES, 32'h0000_0000, MAC_ALL_ONES, 1'b1};
        phase_cfg[4] = '{IP_ALL_ONES, 32'h0000_0000, 32'h0000_0000, MAC_ALL_ONES, 1'b0};

        // registers at reset values: only broadcast and multicast answer
        add_row(0, rslv(IP_ALL_ONES), 1, mk_res(K_SEND, MAC_ALL_ONES, IP_ALL_ONES, 1'b1));
        add_row(0, rslv(32'hE000_0000), 1, mk_res(K_MCAST, MAC_ZERO, 32'hE000_0000, 1'b1));
        add_row(0, rslv(32'hEFFF_FFFF), 1, mk_res(K_MCAST, MAC_ZERO, 32'hEFFF_FFFF, 1'b1));
        add_row(0, rslv(32'h0000_0000), 0);
        add_row(0, rslv(32'h0A00_0001), 0);
        // short body, wrong hardware type, wrong protocol type
        add_row(0, arp_pkt(1'b0, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST, MAC_ALL_ONES,
                           32'h0A00_0001, 32'h0, MAC_ALL_ONES), 0);
        add_row(0, arp_pkt(1'b1, 16'hFFFF, PTYPE_IPV4, OP_REQUEST, MAC_ALL_ONES,
                           32'h0A00_0001, 32'h0, MAC_ALL_ONES), 0);
        add_row(0, arp_pkt(1'b1, HTYPE_ETH, 16'h0000, OP_REQUEST, MAC_ALL_ONES,
                           32'h0A00_0001, 32'h0, MAC_ALL_ONES), 0);
        // request for our (zero) address while no address is configured
        add_row(0, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST, MAC_ZERO,
                           IP_ALL_ONES, 32'h0, MAC_ZERO), 0);

        // address configured
        add_row(1, rslv(32'hC0A8_01FF), 1, mk_res(K_SEND, MAC_ALL_ONES, 32'hC0A8_01FF, 1'b1));
        add_row(1, rslv(32'hC0A8_0114));
        add_row(1, rslv(32'hC0A8_0114));
        add_row(1, rslv(32'h0808_0808));
        add_row(1, rslv(32'hA9FE_0304));
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, 16'd2, MAC_ZERO, 32'hC0A8_0114,
                           DIR_CFG.local_ip, 48'h0000_0000_0001));
        add_row(1, rslv(32'hC0A8_0114));
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST, MAC_ALL_ONES,
                           32'hC0A8_011E, DIR_CFG.local_ip, MAC_ALL_ONES));
        // pending gateway resolved by a request to us: resolved then reply
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST, 48'h0A0B_0C0D_0E0F,
                           32'hC0A8_0101, DIR_CFG.local_ip, MAC_ZERO));
        add_row(1, rslv(32'h0808_0808));
        add_row(1, rslv(32'h0000_0000));
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST, 48'h1234_5678_9ABC,
                           32'hC0A8_0128, 32'hC0A8_0199, 48'h0011_2233_4455));
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, 16'hFFFF, 48'h5566_7788_99AA,
                           32'hC0A8_0132, DIR_CFG.local_ip, 48'h0011_2233_4455));
        add_row(1, rslv(32'hC0A8_0132));
        add_row(1, arp_pkt(1'b1, HTYPE_ETH, PTYPE_IPV4, 16'h0000, 48'h7788_99AA_BBCC,
                           32'hC0A8_0114, DIR_CFG.local_ip, 48'h0011_2233_4455));
        add_row(1, rslv(32'hC0A8_010A));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].addressed && !configured)
            begin
                program_regs(DIR_CFG);
                configured = 1'b1;
            end
            drive_item(directed_rows[i]);
        end

        // random phases, one register setting and idle mix each
        row.addressed = 1'b1;
        row.typed = 1'b0;
        row.n = 0;
        row.r0 = '0;
        row.r1 = '0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            program_regs(phase_cfg[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == PHASE_ITEMS / 2)
                begin
                    wait_idle();
                end
                sender_gap(phase_idle[p]);
                row.it = rand_item(phase_cfg[p]);
                drive_item(row);
            end
        end

        wait_idle();
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
